>>> src/cprc_pkg.sv
package cprc_pkg;

  localparam int unsigned COUNT_BITS     = 4;
  localparam int unsigned IN_WIDTH_BITS  = 12;
  localparam int unsigned WIRE_BITS      = 8;
  localparam int unsigned TOTAL_BITS     = 13;
  localparam int unsigned CFG_DATA_BITS  = 64;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned SLOT_BITS      = 16;
  localparam int unsigned NUM_CLASSES    = 4;
  localparam int unsigned CLASS_BITS     = 2;
  localparam int unsigned WANTED_BITS    = 8;
  localparam int unsigned REGION_BITS    = 3;
  localparam int unsigned MAX_HITS       = 2;

  // Coefficient slots inside one packed line set
  localparam int unsigned SLOT_SLOPE_A = 0;
  localparam int unsigned SLOT_SLOPE_B = 1;
  localparam int unsigned SLOT_ICPT_A  = 2;
  localparam int unsigned SLOT_ICPT_B  = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LINES_ONE_ONE  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LINES_ONE_TWO  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LINES_TWO_ONE  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LINES_TWO_TWO  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WANTED_REGIONS = 3'd4;

  // Region codes
  localparam logic [REGION_BITS-1:0] REGION_NONE  = 3'd0;
  localparam logic [REGION_BITS-1:0] REGION_ONE   = 3'd1;
  localparam logic [REGION_BITS-1:0] REGION_TWO   = 3'd2;
  localparam logic [REGION_BITS-1:0] REGION_THREE = 3'd3;
  localparam logic [REGION_BITS-1:0] REGION_FOUR  = 3'd4;

  typedef enum logic [2:0] {
    RSN_PASS         = 3'd0,
    RSN_NO_HITS      = 3'd1,
    RSN_TOO_MANY     = 3'd2,
    RSN_FIRST_APART  = 3'd3,
    RSN_SECOND_APART = 3'd4,
    RSN_OUTSIDE      = 3'd5
  } cprc_reason_e;

  typedef enum logic [CLASS_BITS-1:0] {
    CLS_ONE_ONE = 2'd0,
    CLS_ONE_TWO = 2'd1,
    CLS_TWO_ONE = 2'd2,
    CLS_TWO_TWO = 2'd3
  } cprc_class_e;

  typedef struct packed {
    logic none;
    logic many;
    logic pair;
    logic apart;
  } cprc_chamber_t;

  typedef struct packed {
    logic above;
    logic below;
  } cprc_side_t;

endpackage

>>> src/cprc_if.sv
interface cprc_event_if import cprc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [COUNT_BITS-1:0]     first_count;
  logic [COUNT_BITS-1:0]     second_count;
  logic [IN_WIDTH_BITS-1:0]  first_width_a;
  logic [IN_WIDTH_BITS-1:0]  first_width_b;
  logic [WIRE_BITS-1:0]      first_wire_a;
  logic [WIRE_BITS-1:0]      first_wire_b;
  logic [IN_WIDTH_BITS-1:0]  second_width_a;
  logic [IN_WIDTH_BITS-1:0]  second_width_b;
  logic [WIRE_BITS-1:0]      second_wire_a;
  logic [WIRE_BITS-1:0]      second_wire_b;

  modport source (
    output valid, first_count, second_count, first_width_a, first_width_b,
           first_wire_a, first_wire_b, second_width_a, second_width_b,
           second_wire_a, second_wire_b,
    input  ready
  );

  modport sink (
    input  valid, first_count, second_count, first_width_a, first_width_b,
           first_wire_a, first_wire_b, second_width_a, second_width_b,
           second_wire_a, second_wire_b,
    output ready
  );
endinterface

interface cprc_result_if import cprc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    accept;
  logic [2:0]              reason;
  logic [CLASS_BITS-1:0]   hit_class;
  logic [REGION_BITS-1:0]  region_found;
  logic [TOTAL_BITS-1:0]   first_total;
  logic [TOTAL_BITS-1:0]   second_total;

  modport source (
    output valid, accept, reason, hit_class, region_found, first_total, second_total,
    input  ready
  );

  modport sink (
    input  valid, accept, reason, hit_class, region_found, first_total, second_total,
    output ready
  );
endinterface

>>> src/cprc_chamber.sv
module cprc_chamber import cprc_pkg::*; #(
  parameter int unsigned USE_BITS = 12
) (
  input  logic [COUNT_BITS-1:0]    count_i,
  input  logic [IN_WIDTH_BITS-1:0] width_a_i,
  input  logic [IN_WIDTH_BITS-1:0] width_b_i,
  input  logic [WIRE_BITS-1:0]     wire_a_i,
  input  logic [WIRE_BITS-1:0]     wire_b_i,
  output logic [USE_BITS:0]        total_o,
  output cprc_chamber_t            status_o
);

  logic [WIRE_BITS:0]  wire_diff;
  logic                adjacent;
  logic [USE_BITS:0]   width_a;
  logic [USE_BITS:0]   width_b;

  assign wire_diff = {1'b0, wire_a_i} - {1'b0, wire_b_i};
  // adjacent when the difference is zero, plus one or minus one
  assign adjacent  = (wire_diff == '0) || (wire_diff == (WIRE_BITS+1)'(1)) ||
                     (wire_diff == '1);

  assign width_a = {1'b0, width_a_i[USE_BITS-1:0]};
  assign width_b = {1'b0, width_b_i[USE_BITS-1:0]};

  always_comb begin
    status_o.none  = (count_i == '0);
    status_o.many  = (count_i > COUNT_BITS'(MAX_HITS));
    status_o.pair  = (count_i == COUNT_BITS'(MAX_HITS));
    status_o.apart = !adjacent;
    total_o        = status_o.pair ? (width_a + width_b) : width_a;
  end

endmodule

>>> src/cprc_line.sv
module cprc_line import cprc_pkg::*; #(
  parameter int unsigned X_BITS    = 13,
  parameter int unsigned COEF_BITS = 16
) (
  input  logic [X_BITS-1:0]           x_i,
  input  logic [X_BITS-1:0]           y_i,
  input  logic signed [COEF_BITS-1:0] slope_i,
  input  logic signed [COEF_BITS-1:0] icpt_i,
  output cprc_side_t                  side_o
);

  localparam int unsigned PROD_BITS = X_BITS + 1 + COEF_BITS;
  localparam int unsigned LINE_BITS = PROD_BITS + 1;

  logic signed [X_BITS:0]         x_s;
  logic signed [PROD_BITS-1:0]    prod;
  logic signed [LINE_BITS-1:0]    line_val;
  logic signed [LINE_BITS-1:0]    y_s;

  assign x_s      = $signed({1'b0, x_i});
  assign prod     = x_s * slope_i;
  assign line_val = LINE_BITS'(prod) + LINE_BITS'(icpt_i);
  assign y_s      = $signed({{(LINE_BITS-X_BITS){1'b0}}, y_i});

  assign side_o.above = (y_s > line_val);
  assign side_o.below = (y_s < line_val);

endmodule

>>> src/cprc_merge.sv
module cprc_merge import cprc_pkg::*; (
  input  logic                    check_i,
  input  cprc_reason_e            pre_reason_i,
  input  cprc_side_t              side_a_i,
  input  cprc_side_t              side_b_i,
  input  logic [1:0]              wanted_i,
  output logic                    accept_o,
  output cprc_reason_e            reason_o,
  output logic [REGION_BITS-1:0]  region_o
);

  logic [REGION_BITS-1:0] region;

  always_comb begin
    priority if (side_a_i.above && side_b_i.above) begin
      region = REGION_TWO;
    end else if (side_a_i.above && side_b_i.below) begin
      region = REGION_ONE;
    end else if (side_a_i.below && side_b_i.above) begin
      region = REGION_THREE;
    end else if (side_a_i.below && side_b_i.below) begin
      region = REGION_FOUR;
    end else begin
      region = REGION_NONE;
    end

    accept_o = check_i && (region != REGION_NONE) &&
               (region == ({1'b0, wanted_i} + REGION_BITS'(1)));
    reason_o = accept_o ? RSN_PASS : pre_reason_i;
    region_o = check_i ? region : REGION_NONE;
  end

endmodule

>>> src/chamber_pulse_region_cut_top.sv
// Channel      Dir  Modport  Transfer when          Payload
// event_in     in   sink     valid && ready         counts, widths, wires of two chambers
// result_out   out  source   valid && ready         accept, reason, class, region, totals
// cfg port     in   -        cfg_we_i high          cfg_index_i selects, cfg_data_i value
//
// One event per cycle unless result_out stalls; every event gives one result.
// Stage 1 runs the two chamber lanes, stage 2 the two line lanes (one 14x16
// multiplier each), stage 3 merges them into the output register.
// Backpressure on result_out stalls only stages that hold data; bubbles close up.
// rst_ni clears stage valids and the configuration registers to zero.
module chamber_pulse_region_cut_top import cprc_pkg::*; #(
  parameter int unsigned WIDTH_BITS = 12,
  parameter int unsigned COEF_BITS  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  cprc_event_if.sink                event_in,
  cprc_result_if.source             result_out
);

  // Only the low WIDTH_BITS of each width port count; the ports carry 12.
  localparam int unsigned USE_BITS = (WIDTH_BITS < IN_WIDTH_BITS) ? WIDTH_BITS
                                                                   : IN_WIDTH_BITS;
  localparam int unsigned SUM_BITS = USE_BITS + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_BITS-1:0] lines_q [NUM_CLASSES];
  logic [WANTED_BITS-1:0]   wanted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        lines_q[i] <= '0;
      end
      wanted_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LINES_ONE_ONE, CFG_LINES_ONE_TWO, CFG_LINES_TWO_ONE, CFG_LINES_TWO_TWO: begin
          lines_q[cfg_index_i[CLASS_BITS-1:0]] <= cfg_data_i;
        end
        CFG_WANTED_REGIONS: begin
          wanted_q <= cfg_data_i[WANTED_BITS-1:0];
        end
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage enables: a stage advances when it is empty or its successor advances
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_en, s2_en, s3_en;

  assign s3_en = !s3_valid_q || result_out.ready;
  assign s2_en = !s2_valid_q || s3_en;
  assign s1_en = !s1_valid_q || s2_en;

  assign event_in.ready = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= event_in.valid;
      if (s2_en) s2_valid_q <= s1_valid_q;
      if (s3_en) s3_valid_q <= s2_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: chamber lanes and count checks
  // ---------------------------------------------------------------------------
  cprc_chamber_t         first_st, second_st;
  logic [SUM_BITS-1:0]   first_sum, second_sum;

  cprc_chamber #(.USE_BITS(USE_BITS)) u_first (
    .count_i   (event_in.first_count),
    .width_a_i (event_in.first_width_a),
    .width_b_i (event_in.first_width_b),
    .wire_a_i  (event_in.first_wire_a),
    .wire_b_i  (event_in.first_wire_b),
    .total_o   (first_sum),
    .status_o  (first_st)
  );

  cprc_chamber #(.USE_BITS(USE_BITS)) u_second (
    .count_i   (event_in.second_count),
    .width_a_i (event_in.second_width_a),
    .width_b_i (event_in.second_width_b),
    .wire_a_i  (event_in.second_wire_a),
    .wire_b_i  (event_in.second_wire_b),
    .total_o   (second_sum),
    .status_o  (second_st)
  );

  cprc_reason_e        s1_reason_d, s1_reason_q;
  cprc_class_e         s1_class_d, s1_class_q;
  logic                s1_check_d, s1_check_q;
  logic [SUM_BITS-1:0] s1_t1_d, s1_t1_q, s1_t2_d, s1_t2_q;

  always_comb begin
    s1_reason_d = RSN_OUTSIDE;
    s1_class_d  = CLS_ONE_ONE;
    s1_check_d  = 1'b0;
    s1_t1_d     = '0;
    s1_t2_d     = '0;
    priority if (first_st.none || second_st.none) begin
      s1_reason_d = RSN_NO_HITS;
    end else if (first_st.many || second_st.many) begin
      s1_reason_d = RSN_TOO_MANY;
    end else begin
      s1_class_d = cprc_class_e'({first_st.pair, second_st.pair});
      priority if (first_st.pair && first_st.apart) begin
        s1_reason_d = RSN_FIRST_APART;
      end else if (second_st.pair && second_st.apart) begin
        s1_reason_d = RSN_SECOND_APART;
      end else begin
        // provisional; the merge stage turns it into a pass where it fits
        s1_reason_d = RSN_OUTSIDE;
        s1_check_d  = 1'b1;
        s1_t1_d     = first_sum;
        s1_t2_d     = second_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_reason_q <= s1_reason_d;
      s1_class_q  <= s1_class_d;
      s1_check_q  <= s1_check_d;
      s1_t1_q     <= s1_t1_d;
      s1_t2_q     <= s1_t2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: line lanes, one per boundary line of the selected set
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_BITS-1:0]    line_set;
  logic signed [COEF_BITS-1:0] slope_a, slope_b, icpt_a, icpt_b;
  cprc_side_t                  side_a, side_b;

  assign line_set = lines_q[s1_class_q];
  assign slope_a  = $signed(line_set[SLOT_SLOPE_A*SLOT_BITS +: COEF_BITS]);
  assign slope_b  = $signed(line_set[SLOT_SLOPE_B*SLOT_BITS +: COEF_BITS]);
  assign icpt_a   = $signed(line_set[SLOT_ICPT_A*SLOT_BITS +: COEF_BITS]);
  assign icpt_b   = $signed(line_set[SLOT_ICPT_B*SLOT_BITS +: COEF_BITS]);

  cprc_line #(.X_BITS(SUM_BITS), .COEF_BITS(COEF_BITS)) u_line_a (
    .x_i     (s1_t1_q),
    .y_i     (s1_t2_q),
    .slope_i (slope_a),
    .icpt_i  (icpt_a),
    .side_o  (side_a)
  );

  cprc_line #(.X_BITS(SUM_BITS), .COEF_BITS(COEF_BITS)) u_line_b (
    .x_i     (s1_t1_q),
    .y_i     (s1_t2_q),
    .slope_i (slope_b),
    .icpt_i  (icpt_b),
    .side_o  (side_b)
  );

  cprc_reason_e        s2_reason_q;
  cprc_class_e         s2_class_q;
  logic                s2_check_q;
  logic [SUM_BITS-1:0] s2_t1_q, s2_t2_q;
  cprc_side_t          s2_side_a_q, s2_side_b_q;

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_reason_q <= s1_reason_q;
      s2_class_q  <= s1_class_q;
      s2_check_q  <= s1_check_q;
      s2_t1_q     <= s1_t1_q;
      s2_t2_q     <= s1_t2_q;
      s2_side_a_q <= side_a;
      s2_side_b_q <= side_b;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: merge lane results, compare with the wanted region, output register
  // ---------------------------------------------------------------------------
  logic                   merge_accept;
  cprc_reason_e           merge_reason;
  logic [REGION_BITS-1:0] merge_region;

  cprc_merge u_merge (
    .check_i      (s2_check_q),
    .pre_reason_i (s2_reason_q),
    .side_a_i     (s2_side_a_q),
    .side_b_i     (s2_side_b_q),
    .wanted_i     (wanted_q[{s2_class_q, 1'b0} +: 2]),
    .accept_o     (merge_accept),
    .reason_o     (merge_reason),
    .region_o     (merge_region)
  );

  logic                   s3_accept_q;
  cprc_reason_e           s3_reason_q;
  cprc_class_e            s3_class_q;
  logic [REGION_BITS-1:0] s3_region_q;
  logic [TOTAL_BITS-1:0]  s3_t1_q, s3_t2_q;

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      s3_accept_q <= merge_accept;
      s3_reason_q <= merge_reason;
      s3_class_q  <= s2_class_q;
      s3_region_q <= merge_region;
      s3_t1_q     <= TOTAL_BITS'(s2_t1_q);
      s3_t2_q     <= TOTAL_BITS'(s2_t2_q);
    end
  end

  assign result_out.valid        = s3_valid_q;
  assign result_out.accept       = s3_accept_q;
  assign result_out.reason       = s3_reason_q;
  assign result_out.hit_class    = s3_class_q;
  assign result_out.region_found = s3_region_q;
  assign result_out.first_total  = s3_t1_q;
  assign result_out.second_total = s3_t2_q;

endmodule

>>> src/cprc_checker.sv
module cprc_checker import cprc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic                   out_accept_i,
  input logic [2:0]             out_reason_i,
  input logic [CLASS_BITS-1:0]  out_class_i,
  input logic [REGION_BITS-1:0] out_region_i,
  input logic [TOTAL_BITS-1:0]  out_first_total_i,
  input logic [TOTAL_BITS-1:0]  out_second_total_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({out_accept_i, out_reason_i, out_class_i, out_region_i,
               out_first_total_i, out_second_total_i}))
    else $error("result changed while stalled");

  // With the output register empty, the whole pipeline advances
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output register");

  a_accept_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_accept_i |-> out_reason_i == RSN_PASS &&
      out_region_i != REGION_NONE)
    else $error("accepted event without pass reason or region");

  a_count_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_reason_i == RSN_NO_HITS || out_reason_i == RSN_TOO_MANY) |->
      !out_accept_i && out_class_i == CLS_ONE_ONE && out_region_i == REGION_NONE &&
      out_first_total_i == '0 && out_second_total_i == '0)
    else $error("count reject carries nonzero fields");

  a_apart_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_reason_i == RSN_FIRST_APART || out_reason_i == RSN_SECOND_APART)
      |-> !out_accept_i && out_region_i == REGION_NONE &&
      out_first_total_i == '0 && out_second_total_i == '0)
    else $error("wire reject carries region or totals");

endmodule

bind chamber_pulse_region_cut_top cprc_checker u_cprc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_ready_i         (event_in.ready),
  .out_valid_i        (result_out.valid),
  .out_ready_i        (result_out.ready),
  .out_accept_i       (result_out.accept),
  .out_reason_i       (result_out.reason),
  .out_class_i        (result_out.hit_class),
  .out_region_i       (result_out.region_found),
  .out_first_total_i  (result_out.first_total),
  .out_second_total_i (result_out.second_total)
);

>>> tb/sv/chamber_pulse_region_cut_top_tb.sv
`timescale 1ns / 1ps

module chamber_pulse_region_cut_top_tb;
  import cprc_pkg::*;

  localparam int unsigned TB_WIDTH_BITS = 12;
  localparam int unsigned TB_COEF_BITS  = 16;

  // Pipeline is three stages deep.
  localparam int unsigned DRAIN_CYCLES = 6;
  // Worst case is roughly 1900 events, each behind the longest source gap and the
  // longest sink stall, plus configuration phases; take it several times over.
  localparam int unsigned CYCLE_LIMIT  = 800000;

  localparam int unsigned EXTREME_PHASES      = 4;
  localparam int unsigned EXTREME_PHASE_ITEMS = 80;
  localparam int unsigned SWEEP_PHASES        = 7;
  localparam int unsigned SWEEP_PHASE_ITEMS   = 220;
  localparam int unsigned QUIET_PHASE         = 3;
  localparam int unsigned MAX_REPORTS         = 10;

  // First index past the register list; writes there must be ignored.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_UNUSED = CFG_WANTED_REGIONS + 3'd1;

  typedef struct packed {
    logic [COUNT_BITS-1:0]    first_count;
    logic [COUNT_BITS-1:0]    second_count;
    logic [IN_WIDTH_BITS-1:0] first_width_a;
    logic [IN_WIDTH_BITS-1:0] first_width_b;
    logic [WIRE_BITS-1:0]     first_wire_a;
    logic [WIRE_BITS-1:0]     first_wire_b;
    logic [IN_WIDTH_BITS-1:0] second_width_a;
    logic [IN_WIDTH_BITS-1:0] second_width_b;
    logic [WIRE_BITS-1:0]     second_wire_a;
    logic [WIRE_BITS-1:0]     second_wire_b;
  } hit_event_t;

  typedef struct packed {
    logic                   accept;
    cprc_reason_e           reason;
    cprc_class_e            hit_class;
    logic [REGION_BITS-1:0] region_found;
    logic [TOTAL_BITS-1:0]  first_total;
    logic [TOTAL_BITS-1:0]  second_total;
  } cut_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  cprc_event_if  event_bus ();
  cprc_result_if result_bus ();

  chamber_pulse_region_cut_top #(
    .WIDTH_BITS (TB_WIDTH_BITS),
    .COEF_BITS  (TB_COEF_BITS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .event_in    (event_bus),
    .result_out  (result_bus)
  );

  // Shadow copy of the configuration registers, updated on every write.
  logic [CFG_DATA_BITS-1:0] line_sets [NUM_CLASSES];
  logic [WANTED_BITS-1:0]   wanted_regions_q;

  cut_result_t expected_results [$];
  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned cycle_count;
  bit          quiet;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Sign-extend one 16-bit coefficient slot of a packed line set.
  function automatic longint coef(input logic [CFG_DATA_BITS-1:0] line_set,
                                  input int unsigned slot);
    logic signed [SLOT_BITS-1:0] raw;
    raw = line_set[slot*SLOT_BITS +: SLOT_BITS];
    return longint'(raw);
  endfunction

  function automatic bit wires_adjacent(input logic [WIRE_BITS-1:0] a,
                                        input logic [WIRE_BITS-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d >= -1) && (d <= 1);
  endfunction

  function automatic cut_result_t predict_cut(input hit_event_t ev);
    cut_result_t              r;
    logic [CFG_DATA_BITS-1:0] ls;
    longint                   x, y, la, lb;
    logic [REGION_BITS-1:0]   region;
    logic [1:0]               wanted_field;
    logic [CLASS_BITS-1:0]    cls;
    r.accept       = 1'b0;
    r.reason       = RSN_PASS;
    r.hit_class    = CLS_ONE_ONE;
    r.region_found = REGION_NONE;
    r.first_total  = '0;
    r.second_total = '0;
    if (ev.first_count == 0 || ev.second_count == 0) begin
      r.reason = RSN_NO_HITS;
    end else if (ev.first_count > MAX_HITS || ev.second_count > MAX_HITS) begin
      r.reason = RSN_TOO_MANY;
    end else begin
      cls = {ev.first_count == 2, ev.second_count == 2};
      r.hit_class = cprc_class_e'(cls);
      if (ev.first_count == 2 && !wires_adjacent(ev.first_wire_a, ev.first_wire_b)) begin
        r.reason = RSN_FIRST_APART;
      end else if (ev.second_count == 2 &&
                   !wires_adjacent(ev.second_wire_a, ev.second_wire_b)) begin
        r.reason = RSN_SECOND_APART;
      end else begin
        r.first_total = TOTAL_BITS'(ev.first_width_a);
        if (ev.first_count == 2) r.first_total += TOTAL_BITS'(ev.first_width_b);
        r.second_total = TOTAL_BITS'(ev.second_width_a);
        if (ev.second_count == 2) r.second_total += TOTAL_BITS'(ev.second_width_b);
        ls = line_sets[cls];
        x  = longint'(r.first_total);
        y  = longint'(r.second_total);
        la = coef(ls, SLOT_ICPT_A) + x * coef(ls, SLOT_SLOPE_A);
        lb = coef(ls, SLOT_ICPT_B) + x * coef(ls, SLOT_SLOPE_B);
        if (y > la && y > lb)      region = REGION_TWO;
        else if (y > la && y < lb) region = REGION_ONE;
        else if (y < la && y > lb) region = REGION_THREE;
        else if (y < la && y < lb) region = REGION_FOUR;
        else                       region = REGION_NONE;
        r.region_found = region;
        wanted_field   = wanted_regions_q[2*cls +: 2];
        if (region != REGION_NONE && region == ({1'b0, wanted_field} + 3'd1)) begin
          r.accept = 1'b1;
          r.reason = RSN_PASS;
        end else begin
          r.reason = RSN_OUTSIDE;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pack_lines(input int slope_a, input int slope_b,
                                                          input int icpt_a, input int icpt_b);
    return {16'(icpt_b), 16'(icpt_a), 16'(slope_b), 16'(slope_a)};
  endfunction

  function automatic hit_event_t make_event(
    input int n1, input int n2,
    input int w1a, input int w1b, input int r1a, input int r1b,
    input int w2a, input int w2b, input int r2a, input int r2b);
    hit_event_t ev;
    ev.first_count    = COUNT_BITS'(n1);
    ev.second_count   = COUNT_BITS'(n2);
    ev.first_width_a  = IN_WIDTH_BITS'(w1a);
    ev.first_width_b  = IN_WIDTH_BITS'(w1b);
    ev.first_wire_a   = WIRE_BITS'(r1a);
    ev.first_wire_b   = WIRE_BITS'(r1b);
    ev.second_width_a = IN_WIDTH_BITS'(w2a);
    ev.second_width_b = IN_WIDTH_BITS'(w2b);
    ev.second_wire_a  = WIRE_BITS'(r2a);
    ev.second_wire_b  = WIRE_BITS'(r2b);
    return ev;
  endfunction

  // Line set whose two lines tend to cross inside the width plane.
  function automatic logic [CFG_DATA_BITS-1:0] random_lines();
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    return pack_lines(int'($urandom_range(0, 6)) - 3, int'($urandom_range(0, 6)) - 3,
                      int'($urandom_range(0, 8000)) - 2000,
                      int'($urandom_range(0, 12000)) - 2000);
  endfunction

  function automatic hit_event_t random_event();
    hit_event_t               ev;
    int unsigned              pick;
    logic [CFG_DATA_BITS-1:0] ls;
    longint                   t1, target;
    logic [CLASS_BITS-1:0]    cls;
    ev.first_width_a  = IN_WIDTH_BITS'($urandom_range(0, 4095));
    ev.first_width_b  = IN_WIDTH_BITS'($urandom_range(0, 4095));
    ev.second_width_a = IN_WIDTH_BITS'($urandom_range(0, 4095));
    ev.second_width_b = IN_WIDTH_BITS'($urandom_range(0, 4095));
    ev.first_wire_a   = WIRE_BITS'($urandom_range(0, 255));
    ev.first_wire_b   = WIRE_BITS'($urandom_range(0, 255));
    ev.second_wire_a  = WIRE_BITS'($urandom_range(0, 255));
    ev.second_wire_b  = WIRE_BITS'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      // Well-formed event: one or two hits per chamber, neighbors mostly adjacent.
      ev.first_count  = COUNT_BITS'($urandom_range(1, 2));
      ev.second_count = COUNT_BITS'($urandom_range(1, 2));
      if ($urandom_range(0, 9) != 0)
        ev.first_wire_b = ev.first_wire_a + 8'($urandom_range(0, 2)) - 8'd1;
      if ($urandom_range(0, 9) != 0)
        ev.second_wire_b = ev.second_wire_a + 8'($urandom_range(0, 2)) - 8'd1;
      // Now and then pull the point onto one of the two lines.
      if (pick < 12) begin
        cls = {ev.first_count == 2, ev.second_count == 2};
        ls = line_sets[cls];
        t1 = longint'(ev.first_width_a);
        if (ev.first_count == 2) t1 += longint'(ev.first_width_b);
        if ($urandom_range(0, 1) == 0)
          target = coef(ls, SLOT_ICPT_A) + t1 * coef(ls, SLOT_SLOPE_A);
        else
          target = coef(ls, SLOT_ICPT_B) + t1 * coef(ls, SLOT_SLOPE_B);
        if (ev.second_count == 2) target -= longint'(ev.second_width_b);
        if (target >= 0 && target <= 4095) ev.second_width_a = IN_WIDTH_BITS'(target);
      end
    end else if (pick < 92) begin
      ev.first_count  = COUNT_BITS'($urandom_range(0, 15));
      ev.second_count = COUNT_BITS'($urandom_range(0, 15));
    end else begin
      ev.first_count  = COUNT_BITS'($urandom_range(0, 3));
      ev.second_count = COUNT_BITS'($urandom_range(0, 3));
    end
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. All tasks are entered right after a rising edge.
  // ---------------------------------------------------------------------------

  // Present one event and hold it until the transfer; valid stays high on return
  // so that a following event with no gap is presented with valid never dropping.
  task automatic send_event(input hit_event_t ev);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      event_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    event_bus.valid          <= 1'b1;
    event_bus.first_count    <= ev.first_count;
    event_bus.second_count   <= ev.second_count;
    event_bus.first_width_a  <= ev.first_width_a;
    event_bus.first_width_b  <= ev.first_width_b;
    event_bus.first_wire_a   <= ev.first_wire_a;
    event_bus.first_wire_b   <= ev.first_wire_b;
    event_bus.second_width_a <= ev.second_width_a;
    event_bus.second_width_b <= ev.second_width_b;
    event_bus.second_wire_a  <= ev.second_wire_a;
    event_bus.second_wire_b  <= ev.second_wire_b;
    do @(posedge clk); while (event_bus.ready !== 1'b1);
    expected_results = {expected_results, predict_cut(ev)};
  endtask

  // Drop valid, drain every pending result, then let the pipeline settle.
  task automatic wait_idle();
    event_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the enable is high for exactly one edge.
  task automatic write_cfg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (index)
      CFG_LINES_ONE_ONE, CFG_LINES_ONE_TWO,
      CFG_LINES_TWO_ONE, CFG_LINES_TWO_TWO: line_sets[index[CLASS_BITS-1:0]] = value;
      CFG_WANTED_REGIONS:                   wanted_regions_q = value[WANTED_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all_cfg(input logic [CFG_DATA_BITS-1:0] one_one,
                               input logic [CFG_DATA_BITS-1:0] one_two,
                               input logic [CFG_DATA_BITS-1:0] two_one,
                               input logic [CFG_DATA_BITS-1:0] two_two,
                               input logic [WANTED_BITS-1:0] wanted);
    write_cfg(CFG_LINES_ONE_ONE, one_one);
    write_cfg(CFG_LINES_ONE_TWO, one_two);
    write_cfg(CFG_LINES_TWO_ONE, two_one);
    write_cfg(CFG_LINES_TWO_TWO, two_two);
    write_cfg(CFG_WANTED_REGIONS, {{(CFG_DATA_BITS-WANTED_BITS){1'b0}}, wanted});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: every line is y = 0. Cover each rejection path, the
  // order in which they are checked, and the field extremes.
  task automatic test_screening();
    send_event(make_event(0, 0, 4095, 4095, 255, 255, 4095, 4095, 255, 255));
    send_event(make_event(0, 1, 10, 20, 3, 4, 30, 40, 5, 6));
    send_event(make_event(1, 0, 10, 20, 3, 4, 30, 40, 5, 6));
    // No hits wins over too many.
    send_event(make_event(0, 15, 1, 2, 3, 4, 5, 6, 7, 8));
    send_event(make_event(3, 1, 1, 2, 3, 4, 5, 6, 7, 8));
    send_event(make_event(1, 15, 1, 2, 3, 4, 5, 6, 7, 8));
    // Wires two apart in the first chamber.
    send_event(make_event(2, 1, 100, 200, 10, 12, 300, 0, 0, 0));
    send_event(make_event(1, 2, 100, 200, 0, 0, 300, 400, 200, 100));
    // Both chambers apart: the first chamber is reported.
    send_event(make_event(2, 2, 1, 1, 0, 255, 1, 1, 255, 0));
    // Largest sums, wires adjacent at the ends of the range.
    send_event(make_event(2, 2, 4095, 4095, 0, 1, 4095, 4095, 255, 254));
    // Origin sits on both lines.
    send_event(make_event(1, 1, 0, 4095, 255, 0, 0, 4095, 0, 255));
    send_event(make_event(2, 2, 123, 456, 7, 7, 789, 1011, 200, 200));
    wait_idle();
  endtask

  // Indexes past the list must not touch any register.
  task automatic test_unused_index();
    logic [CFG_INDEX_BITS-1:0] idx;
    idx = CFG_FIRST_UNUSED;
    while (idx >= CFG_FIRST_UNUSED) begin
      write_cfg(idx, '1);
      idx = idx + 3'd1;
    end
    send_event(make_event(1, 1, 500, 0, 0, 0, 600, 0, 0, 0));
    wait_idle();
  endtask

  // Hand-placed points in every region and on each line, one line set per class.
  task automatic test_regions();
    // Class fields: one-one wants 3, one-two wants 1, two-one wants 2, two-two 3.
    write_all_cfg(pack_lines(1, -1, 0, 4000), pack_lines(0, 0, 100, 5000),
                  pack_lines(2, -3, -500, 9000), pack_lines(32767, -32768, -32768, 32767),
                  8'b10_01_00_10);
    send_event(make_event(1, 1, 1000, 0, 0, 0, 3500, 0, 0, 0));
    send_event(make_event(1, 1, 1000, 0, 0, 0, 2000, 0, 0, 0));
    send_event(make_event(1, 1, 3000, 0, 0, 0, 2000, 0, 0, 0));
    send_event(make_event(1, 1, 3000, 0, 0, 0, 500, 0, 0, 0));
    send_event(make_event(1, 1, 1000, 0, 0, 0, 1000, 0, 0, 0));
    send_event(make_event(1, 1, 1000, 0, 0, 0, 3000, 0, 0, 0));
    send_event(make_event(1, 2, 77, 0, 0, 0, 2000, 1000, 40, 41));
    send_event(make_event(2, 1, 1000, 1000, 9, 8, 4000, 0, 0, 0));
    send_event(make_event(2, 1, 1000, 1000, 9, 8, 100, 0, 0, 0));
    send_event(make_event(2, 2, 4095, 4095, 128, 129, 4095, 4095, 1, 0));
    send_event(make_event(2, 2, 0, 0, 128, 129, 0, 0, 1, 0));
    wait_idle();
  endtask

  // Coefficients at the corners of their range, wanted fields at both ends.
  task automatic test_config_extremes();
    logic [CFG_DATA_BITS-1:0] ls;
    logic [WANTED_BITS-1:0]   wanted;
    for (int unsigned phase = 0; phase < EXTREME_PHASES; phase++) begin
      case (phase)
        0: begin ls = '1; wanted = 8'hFF; end
        1: begin ls = pack_lines(32767, -32768, -32768, 32767); wanted = 8'h00; end
        2: begin ls = pack_lines(-32768, 32767, 32767, -32768); wanted = 8'hAA; end
        default: begin ls = '0; wanted = 8'h55; end
      endcase
      write_all_cfg(ls, ls, ls, ls, wanted);
      for (int unsigned i = 0; i < EXTREME_PHASE_ITEMS; i++) send_event(random_event());
      wait_idle();
    end
  endtask

  // Random line sets and wanted regions; one phase runs with no idling at all.
  task automatic test_random_sweep();
    for (int unsigned phase = 0; phase < SWEEP_PHASES; phase++) begin
      write_all_cfg(random_lines(), random_lines(), random_lines(), random_lines(),
                    WANTED_BITS'($urandom_range(0, 255)));
      quiet = (phase == QUIET_PHASE);
      for (int unsigned i = 0; i < SWEEP_PHASE_ITEMS; i++) send_event(random_event());
      wait_idle();
      quiet = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("MISMATCH result %0d: %s", result_count, msg);
  endfunction

  // Compare every result transfer against the oldest pending prediction.
  initial begin
    cut_result_t want;
    result_count = 0;
    forever begin
      @(posedge clk);
      if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result with no event pending");
        end else begin
          want = expected_results.pop_front();
          if (result_bus.accept !== want.accept)
            flag_mismatch($sformatf("accept expected %0d got %0d",
                                    want.accept, result_bus.accept));
          if (result_bus.reason !== want.reason)
            flag_mismatch($sformatf("reason expected %0d got %0d",
                                    want.reason, result_bus.reason));
          if (result_bus.hit_class !== want.hit_class)
            flag_mismatch($sformatf("hit_class expected %0d got %0d",
                                    want.hit_class, result_bus.hit_class));
          if (result_bus.region_found !== want.region_found)
            flag_mismatch($sformatf("region_found expected %0d got %0d",
                                    want.region_found, result_bus.region_found));
          if (result_bus.first_total !== want.first_total)
            flag_mismatch($sformatf("first_total expected %0d got %0d",
                                    want.first_total, result_bus.first_total));
          if (result_bus.second_total !== want.second_total)
            flag_mismatch($sformatf("second_total expected %0d got %0d",
                                    want.second_total, result_bus.second_total));
        end
        result_count++;
      end
    end
  end

  // Result sink: stall at random, never two nonblocking writes in one step.
  initial begin
    int unsigned stall;
    stall = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall != 0) begin
        result_bus.ready <= 1'b0;
        stall--;
      end else begin
        result_bus.ready <= 1'b1;
        stall = idle_gap();
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop if the run hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatch_count   = 0;
    quiet            = 1'b0;
    wanted_regions_q = '0;
    for (int i = 0; i < NUM_CLASSES; i++) line_sets[i] = '0;

    // Hold every input at a known value from time zero.
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_LINES_ONE_ONE;
    cfg_data  <= '0;
    event_bus.valid          <= 1'b0;
    event_bus.first_count    <= '0;
    event_bus.second_count   <= '0;
    event_bus.first_width_a  <= '0;
    event_bus.first_width_b  <= '0;
    event_bus.first_wire_a   <= '0;
    event_bus.first_wire_b   <= '0;
    event_bus.second_width_a <= '0;
    event_bus.second_width_b <= '0;
    event_bus.second_wire_a  <= '0;
    event_bus.second_wire_b  <= '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_screening();
    test_unused_index();
    test_regions();
    test_config_extremes();
    test_random_sweep();

    wait_idle();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
